@@ hw/rtl/btpc_pkg.sv @@
package btpc_pkg;

    // port and field widths
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int UT_W   = 16;
    localparam int UPB_W  = 24;
    localparam int UP_W   = 19;
    localparam int T_W    = 16;
    localparam int P_W    = 18;

    // divider geometry: temperature path and pressure path
    localparam int D1_NUM_W  = 27;
    localparam int D1_DEN_W  = 20;
    localparam int D1_SIDE_W = 40;
    localparam int D2_NUM_W  = 33;
    localparam int D2_DEN_W  = 17;
    localparam int D2_SIDE_W = 18;

    // compensation constants
    localparam logic signed [29:0] C_T_OFFSET = 30'sd4000;
    localparam logic [31:0]        C_X3_BIAS  = 32'd32768;
    localparam logic [15:0]        C_P_SCALE  = 16'd50000;
    localparam logic [11:0]        C_P_K1     = 12'd3038;
    localparam logic signed [14:0] C_P_K2     = -15'sd7357;
    localparam logic signed [47:0] C_P_K3     = 48'sd3791;

    localparam logic signed [25:0] C_T_MAX = 26'sd32767;
    localparam logic signed [25:0] C_T_MIN = -26'sd32768;
    localparam logic signed [48:0] C_P_MAX = 49'sd262143;

    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_OSS   = 2'd3
    } t_reg_idx;

endpackage

@@ hw/rtl/btpc_div.sv @@
module btpc_div #(
    parameter int NUM_W  = btpc_pkg::D2_NUM_W,
    parameter int DEN_W  = btpc_pkg::D2_DEN_W,
    parameter int SIDE_W = btpc_pkg::D2_SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import btpc_pkg::*;

    logic              r_vld  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_acc  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              a_vld;
        logic [DEN_W-1:0]  a_rem;
        logic [NUM_W-1:0]  a_acc;
        logic [DEN_W-1:0]  a_den;
        logic [SIDE_W-1:0] a_side;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;

        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_acc  = i_num;
            assign a_den  = i_den;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_acc  = r_acc[k-1];
            assign a_den  = r_den[k-1];
            assign a_side = r_side[k-1];
        end

        assign trial = {a_rem, a_acc[NUM_W-1]};
        assign diff  = trial - {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
            if (i_en) begin
                if (!diff[DEN_W]) begin
                    r_rem[k] <= diff[DEN_W-1:0];
                    r_acc[k] <= {a_acc[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[DEN_W-1:0];
                    r_acc[k] <= {a_acc[NUM_W-2:0], 1'b0};
                end
                r_den[k]  <= a_den;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_acc[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

@@ hw/rtl/baro_temp_pressure_compensation.sv @@
// Throughput: one beat per cycle while o_stall is low; the two restoring
// dividers (27 and 33 stages) resolve one quotient bit per stage, so they set
// the depth, not the rate.
// An output stall moves the waiting result into a skid entry; the input then
// stalls until that entry drains once the output stall ends.
// Reset (i_rst_n low, synchronous) clears all valid bits and the calibration
// registers to zero.
module baro_temp_pressure_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btpc_pkg::ADDR_W-1:0]         paddr,
    input  logic [btpc_pkg::DATA_W-1:0]         pwdata,
    output logic [btpc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [btpc_pkg::UT_W-1:0]           i_raw_temperature,
    input  logic [btpc_pkg::UPB_W-1:0]          i_raw_pressure_bytes,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [btpc_pkg::T_W-1:0]     o_temperature_tenths,
    output logic [btpc_pkg::P_W-1:0]            o_pressure_pa,
    output logic                                o_divide_error
);
    import btpc_pkg::*;

    // configuration
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CAL_A: r_cal_a <= pwdata;
                REG_CAL_B: r_cal_b <= pwdata;
                REG_CAL_C: r_cal_c <= pwdata[31:0];
                REG_OSS:   r_oss   <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CAL_A: prdata = r_cal_a;
            REG_CAL_B: prdata = r_cal_b;
            REG_CAL_C: prdata = {32'd0, r_cal_c};
            REG_OSS:   prdata = {62'd0, r_oss};
        endcase
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = r_cal_a[63:48];
    assign ac2 = r_cal_a[47:32];
    assign ac3 = r_cal_a[31:16];
    assign ac4 = r_cal_a[15:0];
    assign ac5 = r_cal_b[63:48];
    assign ac6 = r_cal_b[47:32];
    assign b1  = r_cal_b[31:16];
    assign b2  = r_cal_b[15:0];
    assign mc  = r_cal_c[31:16];
    assign md  = r_cal_c[15:0];

    // pipeline advance: hold everything while the skid entry is occupied
    logic r_skid_vld;
    logic en;
    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    // stage 1: raw temperature product, shifted raw pressure
    logic signed [16:0]  dt_c;
    logic [UP_W-1:0]     up_c;
    logic                r_s1_vld;
    logic signed [33:0]  r_s1_prod;
    logic [UP_W-1:0]     r_s1_up;

    assign dt_c = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, ac6});
    assign up_c = UP_W'(i_raw_pressure_bytes >> (4'd8 - {2'b00, r_oss}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
        if (en) begin
            r_s1_prod <= dt_c * $signed({1'b0, ac5});
            r_s1_up   <= up_c;
        end
    end

    // stage 2: X1, divisor, magnitudes for the temperature divide
    logic signed [18:0]       x1_c;
    logic signed [19:0]       den_c;
    logic [15:0]              mc_abs_c;
    logic                     r_s2_vld;
    logic [D1_NUM_W-1:0]      r_s2_num;
    logic [D1_DEN_W-1:0]      r_s2_den;
    logic signed [18:0]       r_s2_x1;
    logic                     r_s2_neg;
    logic                     r_s2_dz;
    logic [UP_W-1:0]          r_s2_up;

    assign x1_c     = r_s1_prod[33:15];
    assign den_c    = 20'(x1_c) + 20'(md);
    assign mc_abs_c = mc[15] ? 16'(-mc) : mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (en) begin
            r_s2_num <= {mc_abs_c, 11'd0};
            r_s2_den <= den_c[19] ? 20'(-den_c) : den_c;
            r_s2_x1  <= x1_c;
            r_s2_neg <= mc[15] ^ den_c[19];
            r_s2_dz  <= (den_c == 20'sd0);
            r_s2_up  <= r_s1_up;
        end
    end

    logic                  d1_vld;
    logic [D1_NUM_W-1:0]   d1_quo;
    logic [D1_SIDE_W-1:0]  d1_side;

    btpc_div #(
        .NUM_W  (D1_NUM_W),
        .DEN_W  (D1_DEN_W),
        .SIDE_W (D1_SIDE_W)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_side  ({r_s2_x1, r_s2_neg, r_s2_dz, r_s2_up}),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stage 3: B5
    logic signed [18:0] d1_x1;
    logic               d1_neg;
    logic               d1_dz;
    logic [UP_W-1:0]    d1_up;
    logic signed [27:0] x2_c;
    logic               r_s3_vld;
    logic signed [28:0] r_s3_b5;
    logic               r_s3_dz;
    logic [UP_W-1:0]    r_s3_up;

    assign {d1_x1, d1_neg, d1_dz, d1_up} = d1_side;
    assign x2_c = d1_neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= d1_vld;
        end
        if (en) begin
            r_s3_b5 <= 29'(d1_x1) + 29'(x2_c);
            r_s3_dz <= d1_dz;
            r_s3_up <= d1_up;
        end
    end

    // stage 4: temperature result, B6
    logic signed [29:0] t8_c;
    logic signed [25:0] tt_c;
    logic signed [15:0] tsat_c;
    logic               r_s4_vld;
    logic signed [15:0] r_s4_t;
    logic signed [29:0] r_s4_b6;
    logic               r_s4_dz;
    logic [UP_W-1:0]    r_s4_up;

    assign t8_c = 30'(r_s3_b5) + 30'sd8;
    assign tt_c = t8_c[29:4];

    always_comb begin
        priority if (tt_c > C_T_MAX) begin
            tsat_c = 16'sh7FFF;
        end else if (tt_c < C_T_MIN) begin
            tsat_c = -16'sh8000;
        end else begin
            tsat_c = tt_c[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
        if (en) begin
            r_s4_t  <= tsat_c;
            r_s4_b6 <= 30'(r_s3_b5) - C_T_OFFSET;
            r_s4_dz <= r_s3_dz;
            r_s4_up <= r_s3_up;
        end
    end

    // stage 5: B6 squared and the AC2 / AC3 products
    logic               r_s5_vld;
    logic signed [59:0] r_s5_sqf;
    logic signed [45:0] r_s5_ac2;
    logic signed [45:0] r_s5_ac3;
    logic signed [15:0] r_s5_t;
    logic               r_s5_dz;
    logic [UP_W-1:0]    r_s5_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= r_s4_vld;
        end
        if (en) begin
            r_s5_sqf <= r_s4_b6 * r_s4_b6;
            r_s5_ac2 <= ac2 * r_s4_b6;
            r_s5_ac3 <= ac3 * r_s4_b6;
            r_s5_t   <= r_s4_t;
            r_s5_dz  <= r_s4_dz;
            r_s5_up  <= r_s4_up;
        end
    end

    // stage 6: B1 and B2 products of the scaled square
    logic [46:0]        sq_c;
    logic               r_s6_vld;
    logic signed [63:0] r_s6_b2;
    logic signed [63:0] r_s6_b1;
    logic signed [34:0] r_s6_ac2s;
    logic signed [32:0] r_s6_ac3s;
    logic signed [15:0] r_s6_t;
    logic               r_s6_dz;
    logic [UP_W-1:0]    r_s6_up;

    assign sq_c = r_s5_sqf[58:12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
        end
        if (en) begin
            r_s6_b2   <= b2 * $signed({1'b0, sq_c});
            r_s6_b1   <= b1 * $signed({1'b0, sq_c});
            r_s6_ac2s <= r_s5_ac2[45:11];
            r_s6_ac3s <= r_s5_ac3[45:13];
            r_s6_t    <= r_s5_t;
            r_s6_dz   <= r_s5_dz;
            r_s6_up   <= r_s5_up;
        end
    end

    // stage 7: B3 before the truncating divide by four, second X3
    logic signed [54:0] x3a_c;
    logic signed [59:0] v_c;
    logic signed [48:0] x3b_c;
    logic               r_s7_vld;
    logic signed [59:0] r_s7_v;
    logic [31:0]        r_s7_x3lo;
    logic signed [15:0] r_s7_t;
    logic               r_s7_dz;
    logic [UP_W-1:0]    r_s7_up;

    assign x3a_c = 55'($signed(r_s6_b2[63:11])) + 55'(r_s6_ac2s);
    assign v_c   = ((60'($signed({ac1, 2'b00})) + 60'(x3a_c)) <<< r_oss) + 60'sd2;
    assign x3b_c = 49'(r_s6_ac3s) + 49'(r_s6_b1[63:16]) + 49'sd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s7_vld <= r_s6_vld;
        end
        if (en) begin
            r_s7_v    <= v_c;
            r_s7_x3lo <= x3b_c[33:2];
            r_s7_t    <= r_s6_t;
            r_s7_dz   <= r_s6_dz;
            r_s7_up   <= r_s6_up;
        end
    end

    // stage 8: B3 low word, B4 product
    logic signed [59:0] vadj_c;
    logic [31:0]        x3off_c;
    logic [47:0]        b4full_c;
    logic               r_s8_vld;
    logic [31:0]        r_s8_b3;
    logic [31:0]        r_s8_b4p;
    logic signed [15:0] r_s8_t;
    logic               r_s8_dz;
    logic [UP_W-1:0]    r_s8_up;

    // round toward zero: bias negatives before the shift
    assign vadj_c   = r_s7_v + $signed({58'd0, {2{r_s7_v[59]}}});
    assign x3off_c  = r_s7_x3lo + C_X3_BIAS;
    assign b4full_c = ac4 * x3off_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else if (en) begin
            r_s8_vld <= r_s7_vld;
        end
        if (en) begin
            r_s8_b3  <= vadj_c[33:2];
            r_s8_b4p <= b4full_c[31:0];
            r_s8_t   <= r_s7_t;
            r_s8_dz  <= r_s7_dz;
            r_s8_up  <= r_s7_up;
        end
    end

    // stage 9: B4, B7
    logic [16:0]        b4_c;
    logic [31:0]        diff_c;
    logic [15:0]        scale_c;
    logic [47:0]        b7full_c;
    logic               r_s9_vld;
    logic [31:0]        r_s9_b7;
    logic [16:0]        r_s9_b4;
    logic               r_s9_err;
    logic signed [15:0] r_s9_t;

    assign b4_c     = r_s8_b4p[31:15];
    assign diff_c   = {{(32-UP_W){1'b0}}, r_s8_up} - r_s8_b3;
    assign scale_c  = C_P_SCALE >> r_oss;
    assign b7full_c = diff_c * scale_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_vld <= 1'b0;
        end else if (en) begin
            r_s9_vld <= r_s8_vld;
        end
        if (en) begin
            r_s9_b7  <= b7full_c[31:0];
            r_s9_b4  <= b4_c;
            r_s9_err <= r_s8_dz | (b4_c == 17'd0);
            r_s9_t   <= r_s8_t;
        end
    end

    // pressure divide: double before dividing unless B7 has its top bit set
    logic                  hi_c;
    logic [D2_NUM_W-1:0]   d2_num_c;
    logic                  d2_vld;
    logic [D2_NUM_W-1:0]   d2_quo;
    logic [D2_SIDE_W-1:0]  d2_side;

    assign hi_c     = r_s9_b7[31];
    assign d2_num_c = hi_c ? {1'b0, r_s9_b7} : {r_s9_b7, 1'b0};

    btpc_div #(
        .NUM_W  (D2_NUM_W),
        .DEN_W  (D2_DEN_W),
        .SIDE_W (D2_SIDE_W)
    ) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s9_vld),
        .i_num   (d2_num_c),
        .i_den   (r_s9_b4),
        .i_side  ({hi_c, r_s9_err, r_s9_t}),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage 11: p, its scaled square and linear term
    logic               d2_hi;
    logic               d2_err;
    logic signed [15:0] d2_t;
    logic [32:0]        p_c;
    logic               r_s11_vld;
    logic [32:0]        r_s11_p;
    logic [49:0]        r_s11_sq;
    logic signed [48:0] r_s11_m2;
    logic               r_s11_err;
    logic signed [15:0] r_s11_t;

    assign {d2_hi, d2_err, d2_t} = d2_side;
    assign p_c = d2_hi ? {d2_quo[31:0], 1'b0} : d2_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_vld <= 1'b0;
        end else if (en) begin
            r_s11_vld <= d2_vld;
        end
        if (en) begin
            r_s11_p   <= p_c;
            r_s11_sq  <= p_c[32:8] * p_c[32:8];
            r_s11_m2  <= C_P_K2 * $signed({1'b0, p_c});
            r_s11_err <= d2_err;
            r_s11_t   <= d2_t;
        end
    end

    // stage 12: scale the square term
    logic [61:0]        x1p_c;
    logic               r_s12_vld;
    logic [45:0]        r_s12_x1;
    logic signed [32:0] r_s12_x2;
    logic [32:0]        r_s12_p;
    logic               r_s12_err;
    logic signed [15:0] r_s12_t;

    assign x1p_c = r_s11_sq * C_P_K1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_vld <= 1'b0;
        end else if (en) begin
            r_s12_vld <= r_s11_vld;
        end
        if (en) begin
            r_s12_x1  <= x1p_c[61:16];
            r_s12_x2  <= r_s11_m2[48:16];
            r_s12_p   <= r_s11_p;
            r_s12_err <= r_s11_err;
            r_s12_t   <= r_s11_t;
        end
    end

    // stage 13: final correction, saturation, error zeroing
    logic signed [47:0] sum_c;
    logic signed [48:0] pf_c;
    logic [P_W-1:0]     psat_c;
    logic               r_out_vld;
    logic signed [15:0] r_out_t;
    logic [P_W-1:0]     r_out_p;
    logic               r_out_err;

    assign sum_c = 48'($signed({1'b0, r_s12_x1})) + 48'(r_s12_x2) + C_P_K3;
    assign pf_c  = 49'($signed({1'b0, r_s12_p})) + 49'($signed(sum_c[47:4]));

    always_comb begin
        priority if (pf_c < 49'sd0) begin
            psat_c = '0;
        end else if (pf_c > C_P_MAX) begin
            psat_c = '1;
        end else begin
            psat_c = pf_c[P_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s12_vld;
        end
        if (en) begin
            r_out_t   <= r_s12_err ? 16'sd0 : r_s12_t;
            r_out_p   <= r_s12_err ? '0 : psat_c;
            r_out_err <= r_s12_err;
        end
    end

    // skid entry: catch the beat that leaves the result register while stalled
    logic signed [15:0] r_skid_t;
    logic [P_W-1:0]     r_skid_p;
    logic               r_skid_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_out_vld && i_stall) begin
            r_skid_vld <= 1'b1;
        end
        if (!r_skid_vld) begin
            r_skid_t   <= r_out_t;
            r_skid_p   <= r_out_p;
            r_skid_err <= r_out_err;
        end
    end

    assign o_valid              = r_skid_vld | r_out_vld;
    assign o_temperature_tenths = r_skid_vld ? r_skid_t : r_out_t;
    assign o_pressure_pa        = r_skid_vld ? r_skid_p : r_out_p;
    assign o_divide_error       = r_skid_vld ? r_skid_err : r_out_err;

endmodule

@@ hw/rtl/btpc_checker.sv @@
module btpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_stall,
    input logic signed [btpc_pkg::T_W-1:0] o_temperature_tenths,
    input logic [btpc_pkg::P_W-1:0]        o_pressure_pa,
    input logic                            o_divide_error
);
    import btpc_pkg::*;

    // a stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure_pa)
            && $stable(o_temperature_tenths) && $stable(o_divide_error))
        else $error("stalled result beat changed");

    // error beats carry zero results
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_pressure_pa == '0 && o_temperature_tenths == '0)
        else $error("divide error with nonzero result");

    // input stalls only while a result is pending
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // input stall starts only after an output stall on a valid beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output backpressure");

    // reset leaves the output empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("output not empty after reset");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
    import btpc_pkg::*;

    typedef struct packed {
        logic [UT_W-1:0]  ut;
        logic [UPB_W-1:0] upb;
    } t_sample;

    typedef struct packed {
        logic signed [T_W-1:0] temp;
        logic [P_W-1:0]        press;
        logic                  err;
    } t_reading;

    localparam int QUIET_LIMIT = 5000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [UT_W-1:0]         i_raw_temperature = '0;
    logic [UPB_W-1:0]        i_raw_pressure_bytes = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [T_W-1:0]   o_temperature_tenths;
    logic [P_W-1:0]          o_pressure_pa;
    logic                    o_divide_error;

    logic [63:0] cal_a = '0, cal_b = '0;
    logic [31:0] cal_c = '0;
    logic [1:0]  oss = '0;

    t_sample  pending_samples[$];
    t_reading expected_readings[$];
    int       errors = 0;
    int       send_gap = 0, recv_gap = 0, quiet_cycles = 0;
    bit       calm = 1'b0;

    baro_temp_pressure_compensation dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_reading compensate(t_sample s);
        longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint ut, up, x1, x2, x3, b5, b6, b3, sq, t, p, px;
        logic [63:0] b4, b7, q, w;
        t_reading r;
        ac1 = longint'($signed(cal_a[63:48]));
        ac2 = longint'($signed(cal_a[47:32]));
        ac3 = longint'($signed(cal_a[31:16]));
        ac4 = longint'(cal_a[15:0]);
        ac5 = longint'(cal_b[63:48]);
        ac6 = longint'(cal_b[47:32]);
        b1  = longint'($signed(cal_b[31:16]));
        b2  = longint'($signed(cal_b[15:0]));
        mc  = longint'($signed(cal_c[31:16]));
        md  = longint'($signed(cal_c[15:0]));
        ut  = longint'(s.ut);
        up  = longint'(s.upb >> (8 - oss));
        r = '{temp: '0, press: '0, err: 1'b1};
        x1 = ((ut - ac6) * ac5) >>> 15;
        if (x1 + md == 0) return r;
        x2 = (mc * 2048) / (x1 + md);
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x3 = ((b2 * sq) >>> 11) + ((ac2 * b6) >>> 11);
        b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
        x3 = (((ac3 * b6) >>> 13) + ((b1 * sq) >>> 16) + 2) >>> 2;
        w = 64'(x3 + 32768) & 64'hFFFF_FFFF;
        b4 = ((64'(ac4) * w) & 64'hFFFF_FFFF) >> 15;
        if (b4 == 0) return r;
        b7 = ((64'(up) - 64'(b3)) * 64'(50000 >> oss)) & 64'hFFFF_FFFF;
        if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
        else q = (b7 / b4) * 2;
        p = longint'(q);
        px = (p >>> 8) * (p >>> 8);
        px = (px * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p = p + ((px + x2 + 3791) >>> 4);
        if (p < 0) p = 0;
        if (p > 262143) p = 262143;
        r.temp = T_W'(t);
        r.press = P_W'(p);
        r.err = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: hold the beat until accepted, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_readings.push_back(
                    compensate('{ut: i_raw_temperature, upb: i_raw_pressure_bytes}));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    t_sample s;
                    s = pending_samples.pop_front();
                    i_raw_temperature <= s.ut;
                    i_raw_pressure_bytes <= s.upb;
                    i_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_reading e;
                    e = expected_readings.pop_front();
                    if (o_temperature_tenths !== e.temp)
                        report_mismatch("temperature", o_temperature_tenths, e.temp);
                    if (o_pressure_pa !== e.press)
                        report_mismatch("pressure", o_pressure_pa, e.press);
                    if (o_divide_error !== e.err)
                        report_mismatch("divide_error", o_divide_error, e.err);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)
            || (pending_samples.size() == 0 && !i_valid && expected_readings.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[baro_temp_pressure_compensation] ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CAL_A: cal_a = value;
            REG_CAL_B: cal_b = value;
            REG_CAL_C: cal_c = value[31:0];
            REG_OSS:   oss = value[1:0];
        endcase
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || i_valid || expected_readings.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [63:0] a, logic [63:0] b, logic [31:0] c,
                                    logic [1:0] o);
        drain();
        write_reg(REG_CAL_A, a);
        write_reg(REG_CAL_B, b);
        write_reg(REG_CAL_C, 64'(c));
        write_reg(REG_OSS, 64'(o));
    endtask

    task automatic queue_extremes;
        pending_samples.push_back('{ut: '0, upb: '0});
        pending_samples.push_back('{ut: '1, upb: '1});
        pending_samples.push_back('{ut: '0, upb: '1});
        pending_samples.push_back('{ut: '1, upb: '0});
        pending_samples.push_back('{ut: 16'd27898, upb: 24'(23843) << 8});
        pending_samples.push_back('{ut: 16'h8000, upb: 24'h800000});
        pending_samples.push_back('{ut: 16'h7FFF, upb: 24'h7FFFFF});
    endtask

    task automatic queue_random(int n, bit near_typical);
        repeat (n) begin
            t_sample s;
            s.ut = 16'($urandom);
            s.upb = 24'($urandom);
            if (near_typical && $urandom_range(0, 3) != 0) begin
                s.ut = 16'($urandom_range(20000, 36000));
                s.upb = 24'($urandom_range(20000, 60000)) << $urandom_range(5, 8);
            end
            pending_samples.push_back(s);
        end
    endtask

    // typical calibration words of a real sensor
    localparam logic [63:0] TYP_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
    localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
    localparam logic [31:0] TYP_C = {-16'sd8711, 16'sd2868};

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset calibration: temperature divisor is zero
        queue_extremes();
        queue_random(40, 1'b0);
        load_calibration(TYP_A, TYP_B, TYP_C, 2'd0);
        queue_extremes();
        queue_random(300, 1'b1);
        load_calibration(TYP_A, TYP_B, TYP_C, 2'd3);
        queue_random(300, 1'b1);
        load_calibration('1, '1, '1, 2'd3);
        queue_extremes();
        queue_random(60, 1'b0);
        // zero AC4 gives a zero pressure divisor
        load_calibration({TYP_A[63:16], 16'd0}, TYP_B, TYP_C, 2'd1);
        queue_random(60, 1'b1);
        load_calibration({16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                         {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF},
                         {16'h8000, 16'h7FFF}, 2'd2);
        queue_random(60, 1'b0);
        repeat (6) begin
            logic [63:0] a, b;
            logic [31:0] c;
            a = TYP_A ^ {32'($urandom_range(0, 255)), 32'($urandom_range(0, 255))};
            b = TYP_B ^ {32'($urandom_range(0, 255)), 32'($urandom_range(0, 255))};
            c = TYP_C ^ 32'($urandom_range(0, 1023));
            if ($urandom_range(0, 2) == 0) begin
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
                c = $urandom;
            end
            load_calibration(a, b, c, 2'($urandom_range(0, 3)));
            queue_random(160, 1'b1);
        end
        drain();
        calm = 1'b1;
        queue_random(150, 1'b1);
        drain();
        repeat (150) @(posedge i_clk);
        if (errors == 0)
            $display("[baro_temp_pressure_compensation] OK");
        else
            $display("[baro_temp_pressure_compensation] ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_div.sv
hw/rtl/baro_temp_pressure_compensation.sv
hw/rtl/btpc_checker.sv
tb/sv/testbench.sv
